[design/pair_co_membership_agreement_defines.svh]
// Assertion helpers for the pair co-membership agreement block.
`ifndef PAIR_CO_MEMBERSHIP_AGREEMENT_DEFINES_SVH
`define PAIR_CO_MEMBERSHIP_AGREEMENT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define PCMA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("pcma assertion failed");

// Check that a trigger is followed by a condition at the next clock edge.
`define PCMA_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("pcma assertion failed");

`else

`define PCMA_ASSERT_ALWAYS(label, cond)
`define PCMA_ASSERT_NEXT(label, trig, cond)

`endif

`endif

[design/pcma_pkg.sv]
`default_nettype none

package pcma_pkg;

    localparam int MAX_FEATURES_DEF = 256;
    localparam int LABEL_BITS_DEF   = 16;

    localparam int BLOCK_W = 16;
    localparam int COUNT_W = 15;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 64;

    // Register indexes (byte address = 8 * index).
    localparam logic [1:0] REG_REF_FINGERPRINT  = 2'd0;
    localparam logic [1:0] REG_CAND_FINGERPRINT = 2'd1;
    localparam logic [1:0] REG_REF_VERSION      = 2'd2;
    localparam logic [1:0] REG_CAND_VERSION     = 2'd3;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_AXES     = 2'd1,
        STATUS_CAPACITY = 2'd2
    } status_t;

    // Feature request as it travels down the cell chain.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               placed;
        logic [BLOCK_W-1:0] reference_block;
        logic [BLOCK_W-1:0] candidate_block;
        logic [COUNT_W-1:0] pairs;
        logic [COUNT_W-1:0] agreements;
    } token_t;

endpackage

`default_nettype wire

[design/pcma_cell.sv]
`default_nettype none

module pcma_cell #(
    parameter int LABEL_BITS = pcma_pkg::LABEL_BITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire pcma_pkg::token_t tok_in,
    output pcma_pkg::token_t     tok_out
);

    localparam int KeepBits = (LABEL_BITS < pcma_pkg::BLOCK_W) ? LABEL_BITS
                                                                : pcma_pkg::BLOCK_W;

    logic                valid_reg, valid_next;
    logic [KeepBits-1:0] ref_label_reg, ref_label_next;
    logic [KeepBits-1:0] cand_label_reg, cand_label_next;
    pcma_pkg::token_t    tok_reg, tok_next;
    logic                ref_same, cand_same;

    assign ref_same  = ref_label_reg == tok_in.reference_block[KeepBits-1:0];
    assign cand_same = cand_label_reg == tok_in.candidate_block[KeepBits-1:0];

    always_comb begin
        tok_next        = tok_in;
        valid_next      = valid_reg;
        ref_label_next  = ref_label_reg;
        cand_label_next = cand_label_reg;
        if (tok_in.valid && !tok_in.placed) begin
            if (valid_reg) begin
                // compare with the stored feature; a final feature empties the cell
                tok_next.pairs = tok_in.pairs + pcma_pkg::COUNT_W'(1);
                if (ref_same == cand_same) begin
                    tok_next.agreements = tok_in.agreements + pcma_pkg::COUNT_W'(1);
                end
                if (tok_in.last) begin
                    valid_next = 1'b0;
                end
            end else begin
                // first free cell: claim it
                tok_next.placed = 1'b1;
                if (!tok_in.last) begin
                    valid_next      = 1'b1;
                    ref_label_next  = tok_in.reference_block[KeepBits-1:0];
                    cand_label_next = tok_in.candidate_block[KeepBits-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ref_label_reg  <= ref_label_next;
            cand_label_reg <= cand_label_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

[design/pcma_config.sv]
`default_nettype none

module pcma_config (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pcma_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pcma_pkg::DATA_W-1:0] pwdata,
    output logic      [pcma_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output logic                             axes_mismatch
);

    logic [63:0] ref_fp_reg;
    logic [63:0] cand_fp_reg;
    logic [31:0] ref_ver_reg;
    logic [31:0] cand_ver_reg;
    logic [1:0]  reg_index;
    logic        write_en;

    assign reg_index = paddr[4:3];
    assign write_en  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_fp_reg   <= '0;
            cand_fp_reg  <= '0;
            ref_ver_reg  <= '0;
            cand_ver_reg <= '0;
        end else if (write_en) begin
            case (reg_index)
                pcma_pkg::REG_REF_FINGERPRINT:  ref_fp_reg   <= pwdata;
                pcma_pkg::REG_CAND_FINGERPRINT: cand_fp_reg  <= pwdata;
                pcma_pkg::REG_REF_VERSION:      ref_ver_reg  <= pwdata[31:0];
                pcma_pkg::REG_CAND_VERSION:     cand_ver_reg <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            pcma_pkg::REG_REF_FINGERPRINT:  prdata = ref_fp_reg;
            pcma_pkg::REG_CAND_FINGERPRINT: prdata = cand_fp_reg;
            pcma_pkg::REG_REF_VERSION:      prdata = {32'd0, ref_ver_reg};
            pcma_pkg::REG_CAND_VERSION:     prdata = {32'd0, cand_ver_reg};
            default:                        prdata = '0;
        endcase
    end

    assign axes_mismatch = (ref_fp_reg != cand_fp_reg) || (ref_ver_reg != cand_ver_reg);

endmodule

`default_nettype wire

[design/pcma_tail.sv]
`default_nettype none

module pcma_tail (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire pcma_pkg::token_t             tok_in,
    input  wire logic                         axes_mismatch,
    input  wire logic                         m_ready,
    output logic                              advance,
    output logic                              m_valid,
    output logic [1:0]                        m_status,
    output logic [pcma_pkg::COUNT_W-1:0]      m_pair_count,
    output logic [pcma_pkg::COUNT_W-1:0]      m_agreement_count,
    output logic [pcma_pkg::COUNT_W-1:0]      m_disagreement_count
);

    `include "pair_co_membership_agreement_defines.svh"

    logic [pcma_pkg::COUNT_W-1:0] pairs_reg, pairs_next;
    logic [pcma_pkg::COUNT_W-1:0] agree_reg, agree_next;
    logic                         overflow_reg, overflow_next;
    logic                         out_valid_reg, out_valid_next;
    pcma_pkg::status_t            status_reg, status_next;
    logic [pcma_pkg::COUNT_W-1:0] out_pairs_reg, out_pairs_next;
    logic [pcma_pkg::COUNT_W-1:0] out_agree_reg, out_agree_next;
    logic [pcma_pkg::COUNT_W-1:0] sum_pairs, sum_agree;
    logic                         sum_overflow;
    logic                         emit;

    // hold the chain only while a final request waits behind a full output
    assign advance = !(tok_in.valid && tok_in.last && out_valid_reg && !m_ready);
    assign emit    = advance && tok_in.valid && tok_in.last;

    assign sum_pairs    = pairs_reg + tok_in.pairs;
    assign sum_agree    = agree_reg + tok_in.agreements;
    assign sum_overflow = overflow_reg || !tok_in.placed;

    always_comb begin
        pairs_next    = pairs_reg;
        agree_next    = agree_reg;
        overflow_next = overflow_reg;
        if (advance && tok_in.valid) begin
            if (tok_in.last) begin
                pairs_next    = '0;
                agree_next    = '0;
                overflow_next = 1'b0;
            end else begin
                pairs_next    = sum_pairs;
                agree_next    = sum_agree;
                overflow_next = sum_overflow;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        status_next    = status_reg;
        out_pairs_next = out_pairs_reg;
        out_agree_next = out_agree_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            if (axes_mismatch) begin
                status_next    = pcma_pkg::STATUS_AXES;
                out_pairs_next = '0;
                out_agree_next = '0;
            end else if (sum_overflow) begin
                status_next    = pcma_pkg::STATUS_CAPACITY;
                out_pairs_next = '0;
                out_agree_next = '0;
            end else begin
                status_next    = pcma_pkg::STATUS_OK;
                out_pairs_next = sum_pairs;
                out_agree_next = sum_agree;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pairs_reg     <= '0;
            agree_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pairs_reg     <= pairs_next;
            agree_reg     <= agree_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        out_pairs_reg <= out_pairs_next;
        out_agree_reg <= out_agree_next;
    end

    assign m_valid              = out_valid_reg;
    assign m_status             = status_reg;
    assign m_pair_count         = out_pairs_reg;
    assign m_agreement_count    = out_agree_reg;
    assign m_disagreement_count = out_pairs_reg - out_agree_reg;

    `PCMA_ASSERT_ALWAYS(a_hold_only_on_stall, advance || (out_valid_reg && !m_ready))
    `PCMA_ASSERT_ALWAYS(a_error_zero_counts, !out_valid_reg || status_reg == pcma_pkg::STATUS_OK || (out_pairs_reg == '0 && out_agree_reg == '0))
    `PCMA_ASSERT_NEXT(a_final_clears, emit, pairs_reg == '0 && agree_reg == '0 && !overflow_reg)
    `PCMA_ASSERT_NEXT(a_emit_shows, emit, out_valid_reg)

endmodule

`default_nettype wire

[design/pair_co_membership_agreement.sv]
// Channel  | Ports                                                      | Accepted when
// ---------+------------------------------------------------------------+----------------------
// input    | s_valid s_ready s_reference_block s_candidate_block        | s_valid && s_ready
//          | s_last_feature                                             |
// result   | m_valid m_ready m_status m_pair_count m_agreement_count    | m_valid && m_ready
//          | m_disagreement_count                                       |
// config   | psel penable pwrite paddr pwdata prdata pready (8*index)   | psel penable pwrite
//
// One request enters per cycle while s_ready is high; a result appears after its final
//   request has passed every cell, one per advancing cycle, and then the output register.
// Reset (aresetn low, synchronous) empties all cells, counters and the output register;
//   the label store needs no clearing pass since empty cells are marked invalid.
// The whole chain holds only while a final request sits at the tail and the previous
//   result has not been taken; s_ready drops for exactly those cycles.
`default_nettype none

module pair_co_membership_agreement #(
    parameter int MAX_FEATURES = pcma_pkg::MAX_FEATURES_DEF,
    parameter int LABEL_BITS   = pcma_pkg::LABEL_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [pcma_pkg::BLOCK_W-1:0] s_reference_block,
    input  wire logic [pcma_pkg::BLOCK_W-1:0] s_candidate_block,
    input  wire logic                         s_last_feature,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [1:0]                        m_status,
    output logic [pcma_pkg::COUNT_W-1:0]      m_pair_count,
    output logic [pcma_pkg::COUNT_W-1:0]      m_agreement_count,
    output logic [pcma_pkg::COUNT_W-1:0]      m_disagreement_count,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pcma_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pcma_pkg::DATA_W-1:0]  pwdata,
    output logic      [pcma_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);

    // tok_chain[i] feeds cell i; tok_chain[MAX_FEATURES] leaves the last cell
    pcma_pkg::token_t tok_chain [0:MAX_FEATURES];
    logic             advance;
    logic             axes_mismatch;

    // Build the request that enters cell 0: no comparisons yet, no cell claimed.
    assign tok_chain[0] = '{
        valid:           s_valid,
        last:            s_last_feature,
        placed:          1'b0,
        reference_block: s_reference_block,
        candidate_block: s_candidate_block,
        pairs:           '0,
        agreements:      '0
    };

    // Take a request whenever the chain advances.
    assign s_ready = advance;

    // Each cell holds one stored feature. A passing request is compared with it, or claims
    // it if empty; a final request empties every cell it passes, so the next stream that
    // follows it finds the chain clear.
    for (genvar i = 0; i < MAX_FEATURES; i++) begin : g_cell
        pcma_cell #(
            .LABEL_BITS(LABEL_BITS)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .advance(advance),
            .tok_in (tok_chain[i]),
            .tok_out(tok_chain[i+1])
        );
    end

    // Fingerprint and version registers; the mismatch flag is sampled when a result forms.
    pcma_config u_config (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .axes_mismatch(axes_mismatch)
    );

    // Accumulate per-request counts, flag requests that found no free cell, and drive
    // the result register.
    pcma_tail u_tail (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .tok_in              (tok_chain[MAX_FEATURES]),
        .axes_mismatch       (axes_mismatch),
        .m_ready             (m_ready),
        .advance             (advance),
        .m_valid             (m_valid),
        .m_status            (m_status),
        .m_pair_count        (m_pair_count),
        .m_agreement_count   (m_agreement_count),
        .m_disagreement_count(m_disagreement_count)
    );

endmodule

`default_nettype wire
